[rtl/core/hcbd_pkg.sv]
// hcbd_pkg: shared types and constants of the chunked body decoder
// no dependencies; used by the size line parser and the top level

package hcbd_pkg;

  typedef enum logic [3:0] {
    PH_LEAD     = 4'd0,
    PH_HEX      = 4'd1,
    PH_HEXWS    = 4'd2,
    PH_EXT      = 4'd3,
    PH_DATA     = 4'd4,
    PH_TERM1    = 4'd5,
    PH_TERM2OK  = 4'd6,
    PH_TERM2BAD = 4'd7,
    PH_TRAILER  = 4'd8,
    PH_ERROR    = 4'd9
  } hcbd_phase_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_LINE   = 3'd1,
    ERR_BAD_SIZE  = 3'd2,
    ERR_TOO_SHORT = 3'd3,
    ERR_BAD_TERM  = 3'd4
  } hcbd_err_e;

  typedef struct packed {
    hcbd_phase_e phase;
    logic        digit_seen;
    logic        bad;
    logic        cr_pending;
  } hcbd_line_t;

  localparam logic [7:0] CharCr   = 8'h0D;
  localparam logic [7:0] CharLf   = 8'h0A;
  localparam logic [7:0] CharSemi = 8'h3B;

endpackage

[rtl/core/hcbd_if.sv]
// hcbd_in_if / hcbd_out_if: valid-ready channels of the chunked body decoder
// carry one body byte in, one decoded result out; no dependencies

interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       body_last;

  modport source (output valid, output data_byte, output body_last, input ready);
  modport sink   (input valid, input data_byte, input body_last, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic       body_complete;
  logic [2:0] error_code;

  modport source (output valid, output payload_byte, output payload_valid,
                  output body_complete, output error_code, input ready);
  modport sink   (input valid, input payload_byte, input payload_valid,
                  input body_complete, input error_code, output ready);
endinterface

[rtl/core/hcbd_size_line.sv]
// hcbd_size_line: combinational step of the size line parser for one byte
// handles the pending cr, whitespace trimming, hex digits and extensions; uses hcbd_pkg

module hcbd_size_line #(
  parameter int COUNT_BITS = 32
) (
  input  hcbd_pkg::hcbd_line_t  line_i,
  input  logic [COUNT_BITS-1:0] acc_i,
  input  logic [7:0]            byte_i,
  output logic                  eol_o,
  output hcbd_pkg::hcbd_line_t  line_o,
  output logic [COUNT_BITS-1:0] acc_o
);
  import hcbd_pkg::*;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c <= 8'h39) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  hcbd_line_t            line;
  logic [COUNT_BITS-1:0] acc_add;
  logic                  apply;

  // saturating shift-in of one hex digit
  always_comb begin
    if (acc_i[COUNT_BITS-1 -: 4] != 4'd0) begin
      acc_add = '1;
    end else begin
      acc_add = {acc_i[COUNT_BITS-5:0], hex_val(byte_i)};
    end
  end

  always_comb begin
    line  = line_i;
    acc_o = acc_i;
    eol_o = 1'b0;
    apply = 1'b1;
    if (line_i.cr_pending) begin
      line.cr_pending = 1'b0;
      if (byte_i == CharLf) begin
        eol_o = 1'b1;
        apply = 1'b0;
      end else if (!line.bad && line.phase == PH_HEX) begin
        line.phase = PH_HEXWS;
      end
    end
    if (apply) begin
      if (byte_i == CharCr) begin
        line.cr_pending = 1'b1;
      end else if (!line.bad && line.phase != PH_EXT) begin
        case (line.phase)
          PH_LEAD: begin
            if (is_ws(byte_i)) begin
              line.phase = PH_LEAD;
            end else if (is_hex(byte_i)) begin
              acc_o           = acc_add;
              line.digit_seen = 1'b1;
              line.phase      = PH_HEX;
            end else begin
              line.bad = 1'b1;
              if (byte_i == CharSemi) line.phase = PH_EXT;
            end
          end
          PH_HEX: begin
            if (is_hex(byte_i)) begin
              acc_o = acc_add;
            end else if (is_ws(byte_i)) begin
              line.phase = PH_HEXWS;
            end else if (byte_i == CharSemi) begin
              line.phase = PH_EXT;
            end else begin
              line.bad = 1'b1;
            end
          end
          default: begin
            if (!is_ws(byte_i)) line.bad = 1'b1;
          end
        endcase
      end
    end
    line_o = line;
  end

endmodule

[rtl/core/http_chunked_body_decoder_unit.sv]
// http_chunked_body_decoder_unit: streaming decoder for a chunked http body
// depends on hcbd_pkg, hcbd_if and hcbd_size_line
//
// in_i carries one body byte per transfer with body_last on the final byte.
// out_o carries exactly one result per input transfer: payload_byte with
// payload_valid for chunk data bytes, body_complete on the byte that closes
// the zero-size line, and error_code flagged once on the byte that decides it.
// Later bytes of a failed body give all-zero results until body_last.
// After the transfer with body_last the decoder is back at the start of a
// size line.
// The result of a byte is registered at its transfer edge. Throughput is one
// byte per clock while out_o.ready holds high, set by the single result
// stage that registers the state and the result in the same cycle.
// A stalled receiver holds the result register; in_i.ready follows
// out_o.ready while a result waits, so no byte is lost or repeated.
// Reset puts the parser at the start of a size line with an empty output.

module http_chunked_body_decoder_unit #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcbd_in_if.sink     in_i,
  hcbd_out_if.source  out_o
);
  import hcbd_pkg::*;

  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);

  hcbd_line_t            line_q, line_d, line_cls;
  logic [COUNT_BITS-1:0] acc_q, acc_d, acc_cls;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic                  eol;
  logic                  accept;
  logic                  out_valid_q;
  logic [7:0]            pbyte_q, pbyte_d;
  logic                  pvalid_q, pvalid_d;
  logic                  done_q, done_d;
  hcbd_err_e             err_q, err_d;

  hcbd_size_line #(
    .COUNT_BITS(COUNT_BITS)
  ) u_size_line (
    .line_i(line_q),
    .acc_i (acc_q),
    .byte_i(in_i.data_byte),
    .eol_o (eol),
    .line_o(line_cls),
    .acc_o (acc_cls)
  );

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // next state
  always_comb begin
    line_d = line_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    unique case (line_q.phase) inside
      PH_LEAD, PH_HEX, PH_HEXWS, PH_EXT: begin
        if (!eol) begin
          line_d = line_cls;
          acc_d  = acc_cls;
        end else begin
          if (line_q.bad || !line_q.digit_seen) begin
            line_d.phase = PH_ERROR;
          end else if (acc_q == '0) begin
            line_d.phase = PH_TRAILER;
          end else if (!in_i.body_last) begin
            rem_d        = acc_q;
            line_d.phase = PH_DATA;
          end
          line_d.digit_seen = 1'b0;
          line_d.bad        = 1'b0;
          line_d.cr_pending = 1'b0;
          acc_d             = '0;
        end
      end
      PH_DATA: begin
        rem_d = rem_q - CountOne;
        if (!in_i.body_last && rem_q == CountOne) line_d.phase = PH_TERM1;
      end
      PH_TERM1: begin
        if (!in_i.body_last) begin
          line_d.phase = (in_i.data_byte == CharCr) ? PH_TERM2OK : PH_TERM2BAD;
        end
      end
      PH_TERM2OK, PH_TERM2BAD: begin
        if (line_q.phase == PH_TERM2OK && in_i.data_byte == CharLf) begin
          if (!in_i.body_last) line_d.phase = PH_LEAD;
        end else begin
          line_d.phase = PH_ERROR;
        end
      end
      default: begin
        line_d = line_q;
      end
    endcase
    if (in_i.body_last) begin
      line_d = '{phase: PH_LEAD, digit_seen: 1'b0, bad: 1'b0, cr_pending: 1'b0};
      acc_d  = '0;
      rem_d  = '0;
    end
  end

  // result of the byte
  always_comb begin
    pbyte_d  = 8'h00;
    pvalid_d = 1'b0;
    done_d   = 1'b0;
    err_d    = ERR_NONE;
    unique case (line_q.phase) inside
      PH_LEAD, PH_HEX, PH_HEXWS, PH_EXT: begin
        if (!eol) begin
          if (in_i.body_last) err_d = ERR_NO_LINE;
        end else if (line_q.bad || !line_q.digit_seen) begin
          err_d = ERR_BAD_SIZE;
        end else if (acc_q == '0) begin
          done_d = 1'b1;
        end else if (in_i.body_last) begin
          err_d = ERR_TOO_SHORT;
        end
      end
      PH_DATA: begin
        pbyte_d  = in_i.data_byte;
        pvalid_d = 1'b1;
        if (in_i.body_last) err_d = ERR_TOO_SHORT;
      end
      PH_TERM1: begin
        if (in_i.body_last) err_d = ERR_TOO_SHORT;
      end
      PH_TERM2OK, PH_TERM2BAD: begin
        if (line_q.phase == PH_TERM2OK && in_i.data_byte == CharLf) begin
          if (in_i.body_last) err_d = ERR_NO_LINE;
        end else begin
          err_d = ERR_BAD_TERM;
        end
      end
      default: begin
        err_d = ERR_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= '{phase: PH_LEAD, digit_seen: 1'b0, bad: 1'b0, cr_pending: 1'b0};
      acc_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        line_q <= line_d;
        acc_q  <= acc_d;
        rem_q  <= rem_d;
      end
      out_valid_q <= accept || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pbyte_q  <= pbyte_d;
      pvalid_q <= pvalid_d;
      done_q   <= done_d;
      err_q    <= err_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.payload_byte  = pbyte_q;
  assign out_o.payload_valid = pvalid_q;
  assign out_o.body_complete = done_q;
  assign out_o.error_code    = err_q;

  a_payload_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload_valid |->
      (out_o.error_code == ERR_NONE || out_o.error_code == ERR_TOO_SHORT))
    else $error("payload transfer with an unexpected error code");

  a_complete_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.body_complete |->
      (!out_o.payload_valid && out_o.error_code == ERR_NONE))
    else $error("body completion combined with payload or error");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.body_last |=>
      (line_q.phase == PH_LEAD && !line_q.cr_pending && acc_q == '0))
    else $error("parser not restarted after the final byte");

  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q.phase == PH_DATA |-> rem_q != '0)
    else $error("data phase with no bytes left");

  a_no_take_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("input taken while a result is stalled");

endmodule
